FILE: rtl/core/narrowing_shift_round_saturate_macros.svh
// ----------------------------------------------------------------------------
// narrowing shift round saturate - assertion macros
// helpers for concurrent checks in narrowing_shift_round_saturate.sv
// ----------------------------------------------------------------------------
`ifndef NARROWING_SHIFT_ROUND_SATURATE_MACROS_SVH
`define NARROWING_SHIFT_ROUND_SATURATE_MACROS_SVH

// same-cycle implication, disabled during reset
`define NSRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define NSRS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/nsrs_pkg.sv
// ----------------------------------------------------------------------------
// nsrs_pkg
// types and codes of the narrowing shift, round and saturate lane
// ----------------------------------------------------------------------------
`default_nettype none

package nsrs_pkg;

   typedef enum logic [3:0] {
      OP_SRAN    = 4'd0,
      OP_SRARN   = 4'd1,
      OP_SRLN    = 4'd2,
      OP_SRLRN   = 4'd3,
      OP_SSRANS  = 4'd4,
      OP_SSRARNS = 4'd5,
      OP_SSRANU  = 4'd6,
      OP_SSRARNU = 4'd7,
      OP_SSRLNS  = 4'd8,
      OP_SSRLRNS = 4'd9,
      OP_SSRLNU  = 4'd10,
      OP_SSRLRNU = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ES_BYTE   = 2'd0,
      ES_HALF   = 2'd1,
      ES_WORD   = 2'd2,
      ES_DOUBLE = 2'd3
   } esize_type;

   // output treatment after shift and round
   typedef enum logic [2:0] {
      SAT_NONE,
      SAT_SIGNED,
      SAT_UNS_ARITH,
      SAT_SIGNED_LOG,
      SAT_UNS_LOG,
      SAT_ZERO
   } sat_type;

   localparam int unsigned SRC_W = 128;
   localparam int unsigned RES_W = 64;

   typedef struct packed {
      sat_type   mode;
      logic      rnd;
      logic      neg;
      esize_type size;
   } ctrl_type;

   // source with a fill guard bit above and a round guard bit below, so the
   // last bit shifted out lands in bit 0
   typedef struct packed {
      ctrl_type         ctrl;
      logic [SRC_W+1:0] w;
      logic [6:0]       amt;
   } stage_a_type;

   typedef struct packed {
      ctrl_type         ctrl;
      logic [SRC_W+1:0] w;
      logic [3:0]       fine;
   } stage_b_type;

   typedef struct packed {
      ctrl_type         ctrl;
      logic [SRC_W+1:0] w;
   } stage_c_type;

   typedef struct packed {
      ctrl_type         ctrl;
      logic [SRC_W-1:0] v;
   } stage_d_type;

endpackage

`default_nettype wire

FILE: rtl/core/narrowing_shift_round_saturate.sv
// ----------------------------------------------------------------------------
// narrowing_shift_round_saturate
// one lane of a vector narrowing right shift with optional rounding and
// signed or unsigned saturation to half the source width
// ----------------------------------------------------------------------------
// path: accepted requests pass stages a, b, c and d, then the result register
// throughput: one request per cycle while not stalled; five-stage pipeline
// (decode, coarse shift, fine shift, round add, saturate)
// reset: synchronous active-high reset empties every stage; no other state
// ----------------------------------------------------------------------------
`default_nettype none

`include "narrowing_shift_round_saturate_macros.svh"

module narrowing_shift_round_saturate (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_op,
   input  wire logic [1:0]  req_elem_size,
   input  wire logic [63:0] req_value_low,
   input  wire logic [63:0] req_value_high,
   input  wire logic [6:0]  req_shift_amount,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result
);
   import nsrs_pkg::*;

   // stage valids and payloads
   logic        a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   stage_c_type c_ff, c_in;
   stage_d_type d_ff, d_in;
   logic [63:0] rsp_result_ff, rsp_result_in;

   // per-stage advance enables; a stage loads when it is empty or drains
   logic en_a, en_b, en_c, en_d, en_out;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_d      = !d_valid_ff || en_out;
   assign en_c      = !c_valid_ff || en_d;
   assign en_b      = !b_valid_ff || en_c;
   assign en_a      = !a_valid_ff || en_b;
   assign req_stall = !en_a;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // ---------------------------------------------------------------- decode
   op_type   op;
   sat_type  mode;
   logic     arith;
   logic     sign;
   logic [SRC_W-1:0] src;

   assign op = op_type'(req_op);

   always_comb begin
      arith = 1'b0;
      mode  = SAT_ZERO;
      unique case (op)
         OP_SRAN, OP_SRARN: begin
            arith = 1'b1;
            mode  = SAT_NONE;
         end
         OP_SRLN, OP_SRLRN: begin
            mode  = SAT_NONE;
         end
         OP_SSRANS, OP_SSRARNS: begin
            arith = 1'b1;
            mode  = SAT_SIGNED;
         end
         OP_SSRANU, OP_SSRARNU: begin
            arith = 1'b1;
            mode  = SAT_UNS_ARITH;
         end
         OP_SSRLNS, OP_SSRLRNS: begin
            mode  = SAT_SIGNED_LOG;
         end
         OP_SSRLNU, OP_SSRLRNU: begin
            mode  = SAT_UNS_LOG;
         end
         default: begin
            // codes past the last op give a zero result
            mode  = SAT_ZERO;
         end
      endcase
   end

   // extend the 2N-bit source to 128 bits and reduce the count modulo 2N
   always_comb begin
      a_in.ctrl.mode = mode;
      a_in.ctrl.rnd  = req_op[0];
      a_in.ctrl.size = esize_type'(req_elem_size);
      sign = 1'b0;
      src  = '0;
      a_in.amt = '0;
      unique case (esize_type'(req_elem_size))
         ES_BYTE: begin
            sign     = arith && req_value_low[15];
            src      = {{112{sign}}, req_value_low[15:0]};
            a_in.amt = {3'b000, req_shift_amount[3:0]};
         end
         ES_HALF: begin
            sign     = arith && req_value_low[31];
            src      = {{96{sign}}, req_value_low[31:0]};
            a_in.amt = {2'b00, req_shift_amount[4:0]};
         end
         ES_WORD: begin
            sign     = arith && req_value_low[63];
            src      = {{64{sign}}, req_value_low};
            a_in.amt = {1'b0, req_shift_amount[5:0]};
         end
         ES_DOUBLE: begin
            sign     = arith && req_value_high[63];
            src      = {req_value_high, req_value_low};
            a_in.amt = req_shift_amount;
         end
      endcase
      a_in.ctrl.neg = sign;
      // top guard copies the fill bit, bottom guard catches the round bit
      a_in.w = {sign, src, 1'b0};
   end

   // ---------------------------------------------------------- coarse shift
   // shift by multiples of 16; fill comes from the sign guard bit
   always_comb begin
      b_in.ctrl = a_ff.ctrl;
      b_in.fine = a_ff.amt[3:0];
      b_in.w    = $unsigned($signed(a_ff.w) >>> {a_ff.amt[6:4], 4'b0000});
   end

   // ------------------------------------------------------------ fine shift
   always_comb begin
      c_in.ctrl = b_ff.ctrl;
      c_in.w    = $unsigned($signed(b_ff.w) >>> b_ff.fine);
   end

   // ------------------------------------------------------------ round add
   // bit 0 holds the last bit shifted out, zero when the count is zero
   always_comb begin
      d_in.ctrl = c_ff.ctrl;
      d_in.v    = c_ff.w[SRC_W:1] + {{(SRC_W-1){1'b0}}, c_ff.ctrl.rnd & c_ff.w[0]};
   end

   // ------------------------------------------------------------ saturate
   logic [63:0] nmask, smax, smin, low;
   logic        above_n, above_n1, all_n1;

   always_comb begin
      nmask    = '1;
      above_n  = 1'b0;
      above_n1 = 1'b0;
      all_n1   = 1'b0;
      unique case (d_ff.ctrl.size)
         ES_BYTE: begin
            nmask    = 64'h0000_0000_0000_00FF;
            above_n  = |d_ff.v[127:8];
            above_n1 = |d_ff.v[127:7];
            all_n1   = &d_ff.v[127:7];
         end
         ES_HALF: begin
            nmask    = 64'h0000_0000_0000_FFFF;
            above_n  = |d_ff.v[127:16];
            above_n1 = |d_ff.v[127:15];
            all_n1   = &d_ff.v[127:15];
         end
         ES_WORD: begin
            nmask    = 64'h0000_0000_FFFF_FFFF;
            above_n  = |d_ff.v[127:32];
            above_n1 = |d_ff.v[127:31];
            all_n1   = &d_ff.v[127:31];
         end
         ES_DOUBLE: begin
            nmask    = 64'hFFFF_FFFF_FFFF_FFFF;
            above_n  = |d_ff.v[127:64];
            above_n1 = |d_ff.v[127:63];
            all_n1   = &d_ff.v[127:63];
         end
      endcase
      smax = nmask >> 1;
      smin = nmask & ~smax;
      low  = d_ff.v[63:0] & nmask;

      rsp_result_in = '0;
      unique case (d_ff.ctrl.mode)
         SAT_NONE: begin
            rsp_result_in = low;
         end
         SAT_SIGNED: begin
            // fits when everything from bit N-1 up is a copy of the sign
            if (!above_n1 || all_n1) begin
               rsp_result_in = low;
            end else if (d_ff.v[SRC_W-1]) begin
               rsp_result_in = smin;
            end else begin
               rsp_result_in = smax;
            end
         end
         SAT_UNS_ARITH: begin
            // negative sources clamp to zero
            if (d_ff.ctrl.neg) begin
               rsp_result_in = '0;
            end else if (above_n) begin
               rsp_result_in = nmask;
            end else begin
               rsp_result_in = low;
            end
         end
         SAT_SIGNED_LOG: begin
            rsp_result_in = above_n1 ? smax : low;
         end
         SAT_UNS_LOG: begin
            rsp_result_in = above_n ? nmask : low;
         end
         SAT_ZERO: begin
            rsp_result_in = '0;
         end
         default: begin
            rsp_result_in = '0;
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= req_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (en_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ff <= a_in;
      end
      if (en_b) begin
         b_ff <= b_in;
      end
      if (en_c) begin
         c_ff <= c_in;
      end
      if (en_d) begin
         d_ff <= d_in;
      end
      if (en_out) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   // ------------------------------------------------------------ checks
   `NSRS_ASSERT_IMP(a_stall_only_when_full, clock, reset, req_stall, a_valid_ff && b_valid_ff && c_valid_ff && d_valid_ff && rsp_valid_ff && rsp_stall, "request stalled with a free stage")
   `NSRS_ASSERT_NXT(a_accept_fills_first, clock, reset, req_valid && !req_stall, a_valid_ff, "accepted request missing from first stage")
   `NSRS_ASSERT_NXT(a_last_stage_holds, clock, reset, d_valid_ff && !en_out, d_valid_ff, "blocked request dropped from last stage")
   `NSRS_ASSERT_NXT(a_unused_op_zero, clock, reset, d_valid_ff && en_out && (d_ff.ctrl.mode == SAT_ZERO), rsp_result == 64'd0, "unused op code gave a nonzero result")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - narrowing shift, round and saturate lane
// directed table then random requests, all results checked in order against
// the table or a bit-accurate predictor, random backpressure on both sides
// ----------------------------------------------------------------------------

module tb;
   import nsrs_pkg::*;

   // unused op codes, the lane answers them with zero
   localparam logic [3:0] OP_UNUSED_LO = 4'd12;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   localparam int NUM_DIRECTED = 24;
   localparam int NUM_RANDOM   = 1030;
   localparam int NUM_TOTAL    = NUM_DIRECTED + NUM_RANDOM;
   // the last stretch of requests runs with no idling on either side
   localparam int CALM_FROM    = NUM_TOTAL - 200;
   // long receiver hold-off, so the pipeline fills and stalls its input
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 12;
   localparam int STUCK_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_op;
   logic [1:0]  req_elem_size;
   logic [63:0] req_value_low;
   logic [63:0] req_value_high;
   logic [6:0]  req_shift_amount;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result;

   // one row of the directed table; want is only used when typed is set
   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  size;
      logic [63:0] low;
      logic [63:0] high;
      logic [6:0]  amount;
      logic        typed;
      logic [63:0] want;
   } shift_row_type;

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   shift_row_type directed_rows [NUM_DIRECTED] = '{
      // plain truncation
      '{OP_SRAN,    ES_BYTE,   64'h1234, 64'h0, 7'd0,   1'b1, 64'h34},
      // signed clamp, both ends
      '{OP_SSRANS,  ES_BYTE,   64'h7FFF, 64'h0, 7'd0,   1'b1, 64'h7F},
      '{OP_SSRANS,  ES_BYTE,   64'h8000, 64'h0, 7'd0,   1'b1, 64'h80},
      // unsigned clamp from arithmetic shift: negative source gives zero; then logical clamps
      '{OP_SSRANU,  ES_BYTE,   64'h8000, 64'h0, 7'd0,   1'b1, 64'h0},
      '{OP_SSRANU,  ES_BYTE,   64'h1234, 64'h0, 7'd0,   1'b1, 64'hFF},
      '{OP_SSRLNU,  ES_DOUBLE, 64'h0,    ONES,  7'd0,   1'b1, ONES},
      '{OP_SSRLNS,  ES_WORD,   ONES,     64'h0, 7'd0,   1'b1, 64'h7FFF_FFFF},
      // unused codes
      '{OP_UNUSED_LO, ES_BYTE, ONES,     ONES,  7'd127, 1'b1, 64'h0},
      '{OP_UNUSED_HI, ES_DOUBLE, ONES,   ONES,  7'd5,   1'b1, 64'h0},
      // count wraps to zero, so rounding adds nothing
      '{OP_SRARN,   ES_BYTE,   64'hFF,   64'h0, 7'd16,  1'b1, 64'hFF},
      // count taken modulo the source width
      '{OP_SRLN,    ES_HALF,   64'h1_0000, 64'h0, 7'd48, 1'b1, 64'h1},
      // rounding adds the last bit out
      '{OP_SRLRN,   ES_BYTE,   64'h3,    64'h0, 7'd1,   1'b1, 64'h2},
      '{OP_SRARN,   ES_BYTE,   64'hFFFF, 64'h0, 7'd1,   1'b1, 64'h0},
      // rounding carry into the upper half, round at count 127, signed double clamps
      '{OP_SSRLRNU, ES_DOUBLE, ONES,     ONES,  7'd1,   1'b1, ONES},
      '{OP_SSRARNS, ES_DOUBLE, ONES,     SMAX,  7'd127, 1'b1, 64'h1},
      '{OP_SSRANS,  ES_DOUBLE, 64'h0,    SMIN,  7'd0,   1'b1, SMIN},
      '{OP_SSRANS,  ES_DOUBLE, 64'h0,    SMAX,  7'd0,   1'b1, SMAX},
      // the rest go through the predictor
      '{OP_SRLN,    ES_DOUBLE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        7'd64, 1'b0, 64'h0},
      '{OP_SSRARNU, ES_HALF,   64'hDEAD_BEEF_0001_FFFF, 64'h0, 7'd1, 1'b0, 64'h0},
      '{OP_SSRLRNS, ES_HALF,   64'hFFFF_FFFF, 64'h0, 7'd31, 1'b0, 64'h0},
      '{OP_SSRARNS, ES_BYTE,   64'h8000, 64'h0, 7'd15,  1'b0, 64'h0},
      '{OP_SSRLNU,  ES_BYTE,   64'hABCD, 64'h0, 7'd8,   1'b0, 64'h0},
      '{OP_SRLRN,   ES_DOUBLE, ONES,     64'h0, 7'd127, 1'b0, 64'h0},
      '{OP_SSRARNU, ES_BYTE,   64'h7F80, 64'h0, 7'd7,   1'b0, 64'h0}
   };

   logic [63:0] pending_results[$];
   int unsigned requests_taken;
   int unsigned mismatches;
   int unsigned quiet_cycles;
   bit          calm_tail;

   narrowing_shift_round_saturate DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_elem_size    (req_elem_size),
      .req_value_low    (req_value_low),
      .req_value_high   (req_value_high),
      .req_shift_amount (req_shift_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // narrowed result of one request: shift, optional round, then clamp
   function automatic logic [63:0] narrowed_result(input logic [3:0] op,
                                                   input logic [1:0] size,
                                                   input logic [63:0] low,
                                                   input logic [63:0] high,
                                                   input logic [6:0] amount);
      int unsigned         n;
      int unsigned         width;
      int unsigned         count;
      logic [63:0]         nmask;
      logic [127:0]        nmask_wide;
      logic [127:0]        src;
      logic signed [127:0] src_signed;
      logic [127:0]        shifted;
      logic [127:0]        sext;
      logic [63:0]         res;
      logic                arith;
      n     = 8 << size;
      width = 2 * n;
      count = amount & (width - 1);
      nmask = (n == 64) ? ONES : ((64'd1 << n) - 64'd1);
      nmask_wide = {64'd0, nmask};
      case (op)
         OP_SRAN, OP_SRARN, OP_SSRANS, OP_SSRARNS, OP_SSRANU, OP_SSRARNU: arith = 1'b1;
         OP_SRLN, OP_SRLRN, OP_SSRLNS, OP_SSRLRNS, OP_SSRLNU, OP_SSRLRNU: arith = 1'b0;
         default: return 64'd0;
      endcase
      // source sits in the low 2N bits, sign filled above for arithmetic ops
      if (width == 128) begin
         src = {high, low};
      end else begin
         src = {64'd0, low} & ((128'd1 << width) - 128'd1);
         if (arith && src[width-1]) src = src | ~((128'd1 << width) - 128'd1);
      end
      src_signed = src;
      if (arith) shifted = src_signed >>> count;
      else shifted = src >> count;
      // odd codes round with the last bit shifted out
      if (op[0] && count > 0) shifted = shifted + src[count-1];
      case (op)
         OP_SRAN, OP_SRARN, OP_SRLN, OP_SRLRN: begin
            res = shifted[63:0];
         end
         OP_SSRANS, OP_SSRARNS: begin
            sext = shifted[n-1] ? (shifted | ~nmask_wide) : (shifted & nmask_wide);
            if (sext == shifted) res = shifted[63:0];
            else if (shifted[127]) res = 64'd1 << (n - 1);
            else res = nmask >> 1;
         end
         OP_SSRANU, OP_SSRARNU: begin
            if (src[127]) res = 64'd0;
            else if ((shifted >> n) != 128'd0) res = nmask;
            else res = shifted[63:0];
         end
         OP_SSRLNS, OP_SSRLRNS: begin
            res = (shifted > (nmask_wide >> 1)) ? (nmask >> 1) : shifted[63:0];
         end
         default: begin
            res = ((shifted >> n) != 128'd0) ? nmask : shifted[63:0];
         end
      endcase
      return res & nmask;
   endfunction

   task automatic log_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      if (mismatches < MAX_REPORTS)
         $display("mismatch (%s): expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   // sender: directed table first, then random requests
   initial begin
      logic [3:0]   op;
      logic [1:0]   size;
      logic [63:0]  low;
      logic [63:0]  high;
      logic [6:0]   amount;
      logic [63:0]  want;
      logic [127:0] wide;
      int unsigned  n;
      int unsigned  bits;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = 4'd0;
      req_elem_size    = 2'd0;
      req_value_low    = 64'd0;
      req_value_high   = 64'd0;
      req_shift_amount = 7'd0;
      requests_taken   = 0;
      mismatches       = 0;
      calm_tail        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_TOTAL; i++) begin
         if (i >= CALM_FROM) calm_tail = 1'b1;
         if (i < NUM_DIRECTED) begin
            op     = directed_rows[i].op;
            size   = directed_rows[i].size;
            low    = directed_rows[i].low;
            high   = directed_rows[i].high;
            amount = directed_rows[i].amount;
         end else begin
            // mostly defined ops, now and then an unused code
            if ($urandom_range(0, 15) == 0) op = 4'($urandom_range(12, 15));
            else op = 4'($urandom_range(0, 11));
            size = 2'($urandom_range(0, 3));
            n    = 8 << size;
            wide = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 3))
               // magnitudes of every width, either sign, to hit clamp edges
               1: begin
                  bits = $urandom_range(0, 128);
                  wide = wide & ((128'd1 << bits) - 128'd1);
                  if ($urandom_range(0, 1)) wide = -wide;
               end
               // all zeros or all ones with one bit flipped
               2: begin
                  wide = $urandom_range(0, 1) ? '1 : '0;
                  wide[$urandom_range(0, 127)] ^= 1'b1;
               end
               default: ;
            endcase
            {high, low} = wide;
            case ($urandom_range(0, 3))
               1: amount = 7'(n - 1 + $urandom_range(0, 2));
               2: amount = $urandom_range(0, 1) ? 7'(2 * n - 1) : 7'd0;
               default: amount = 7'($urandom_range(0, 127));
            endcase
         end
         if (i < NUM_DIRECTED && directed_rows[i].typed) want = directed_rows[i].want;
         else want = narrowed_result(op, size, low, high, amount);
         // random sender gap before this request
         if (!calm_tail && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         req_valid        <= 1'b1;
         req_op           <= op;
         req_elem_size    <= size;
         req_value_low    <= low;
         req_value_high   <= high;
         req_shift_amount <= amount;
         // hold the request until the edge that takes it
         @(negedge clock);
         while (req_stall) @(negedge clock);
         pending_results.push_back(want);
         requests_taken++;
         @(posedge clock);
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // receiver: random stall bursts plus one long hold-off
   initial begin
      bit held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(posedge clock);
         if (!held && requests_taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result check and watchdog, sampled mid-cycle where everything is settled
   always @(negedge clock) begin
      logic [63:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               log_mismatch("unexpected result", 64'd0, rsp_result);
            end else begin
               want = pending_results.pop_front();
               if (rsp_result !== want) log_mismatch("result", want, rsp_result);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end else begin
         quiet_cycles = 0;
      end
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/nsrs_pkg.sv
rtl/core/narrowing_shift_round_saturate.sv
tb/tb.sv
